>>> sv/sqve_pkg.sv
// ============================================================================
// sqve_pkg: shared types and constants for the sprite quad vertex expander
// Holds the request codes, status codes, CORDIC constants and the queue entry.
// ============================================================================
`default_nettype none
package sqve_pkg;

  localparam int MaxSlotsDefault = 32;
  localparam int MaxQuadsDefault = 8192;

  // request codes
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_PLAIN = 2'd1;
  localparam logic [1:0] REQ_TEX   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SLOT_FULL = 2'd1;
  localparam logic [1:0] ST_QUAD_FULL = 2'd2;

  localparam int CordicSteps = 16;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [15:0] TILING_ONE = 16'h0100;

  function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0:  atan_turn = 34'sd536870912;
      4'd1:  atan_turn = 34'sd316933406;
      4'd2:  atan_turn = 34'sd167458907;
      4'd3:  atan_turn = 34'sd85004756;
      4'd4:  atan_turn = 34'sd42667331;
      4'd5:  atan_turn = 34'sd21354465;
      4'd6:  atan_turn = 34'sd10679838;
      4'd7:  atan_turn = 34'sd5340245;
      4'd8:  atan_turn = 34'sd2670163;
      4'd9:  atan_turn = 34'sd1335087;
      4'd10: atan_turn = 34'sd667544;
      4'd11: atan_turn = 34'sd333772;
      4'd12: atan_turn = 34'sd166886;
      4'd13: atan_turn = 34'sd83443;
      4'd14: atan_turn = 34'sd41722;
      default: atan_turn = 34'sd20861;
    endcase
  endfunction

  // classified quad handed from front to back
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        pos_z;
    logic [15:0]        angle;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        tiling;
    logic [31:0]        colour;
    logic [4:0]         slot;
    logic               fresh;
    logic [14:0]        base_addr;
  } quad_t;

endpackage
`default_nettype wire

>>> sv/sqve_ram.sv
// ============================================================================
// sqve_ram: generic single-port-write RAM with registered read
// One write port, one read port, read data valid the cycle after the address.
// ============================================================================
`default_nettype none
module sqve_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/sqve_front.sv
// ============================================================================
// sqve_front: request intake and texture slot lookup
// Tracks quad and slot counts, searches the slot table entry by entry,
// appends new handles and pushes a classified quad into the queue.
// ============================================================================
`default_nettype none
module sqve_front
  import sqve_pkg::*;
#(
  parameter int MaxSlots = MaxSlotsDefault,
  parameter int MaxQuads = MaxQuadsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_valid,
  output logic              s_ready,
  input  wire logic [1:0]   req_type,
  input  wire logic [31:0]  pos_x,
  input  wire logic [31:0]  pos_y,
  input  wire logic [31:0]  pos_z,
  input  wire logic [15:0]  angle,
  input  wire logic [31:0]  size_x,
  input  wire logic [31:0]  size_y,
  input  wire logic [31:0]  texture_handle,
  input  wire logic [15:0]  tiling,
  input  wire logic [31:0]  colour,
  output logic              q_push,
  output quad_t             q_data,
  input  wire logic         q_full
);

  localparam int SlotW = $clog2(MaxSlots);
  localparam int CntW  = $clog2(MaxSlots + 1);
  localparam int QuadW = $clog2(MaxQuads + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_CHECK, S_PUSH} state_t;

  state_t              state;
  logic [CntW-1:0]     slots_used;
  logic [QuadW-1:0]    quads_used;
  logic [CntW-1:0]     idx;
  logic [31:0]         handle;
  quad_t               held;

  logic                ram_we;
  logic [SlotW-1:0]    ram_waddr;
  logic [SlotW-1:0]    ram_raddr;
  logic [31:0]         ram_rdata;

  sqve_ram #(.Width(32), .Depth(MaxSlots)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (handle),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_ready   = (state == S_IDLE);
  assign ram_raddr = idx[SlotW-1:0];
  assign ram_waddr = slots_used[SlotW-1:0];
  assign ram_we    = (state == S_SEARCH) && (idx >= slots_used) &&
                     (slots_used < CntW'(MaxSlots));
  assign q_push    = (state == S_PUSH) && !q_full;
  assign q_data    = held;

  // intake, search sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slots_used <= CntW'(1);
      quads_used <= '0;
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_valid) begin
            held.pos_x     <= pos_x;
            held.pos_y     <= pos_y;
            held.pos_z     <= pos_z;
            held.angle     <= angle;
            held.size_x    <= size_x;
            held.size_y    <= size_y;
            held.colour    <= colour;
            held.slot      <= '0;
            held.fresh     <= 1'b0;
            held.status    <= ((req_type == REQ_PLAIN || req_type == REQ_TEX) &&
                               quads_used >= QuadW'(MaxQuads)) ? ST_QUAD_FULL : ST_OK;
            held.base_addr <= 15'(quads_used) << 2;
            handle         <= texture_handle;
            held.tiling    <= (req_type == REQ_TEX) ? tiling : TILING_ONE;
            idx            <= CntW'(1);
            if (req_type == REQ_BEGIN) begin
              quads_used <= '0;
              slots_used <= CntW'(1);
            end else if (req_type == REQ_PLAIN || req_type == REQ_TEX) begin
              if (quads_used >= QuadW'(MaxQuads)) begin
                state <= S_PUSH;
              end else if (req_type == REQ_TEX) begin
                state <= S_SEARCH;
              end else begin
                state <= S_PUSH;
              end
            end
          end
        end
        S_SEARCH: begin
          // read of idx issued; compare next cycle
          if (idx >= slots_used) begin
            if (slots_used >= CntW'(MaxSlots)) begin
              held.status <= ST_SLOT_FULL;
            end else begin
              held.slot  <= 5'(slots_used);
              held.fresh <= 1'b1;
              slots_used <= slots_used + CntW'(1);
            end
            state <= S_PUSH;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ram_rdata == handle) begin
            held.slot <= 5'(idx);
            state     <= S_PUSH;
          end else begin
            idx   <= idx + CntW'(1);
            state <= S_SEARCH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            if (held.status == ST_OK) begin
              quads_used <= quads_used + QuadW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/sqve_queue.sv
// ============================================================================
// sqve_queue: two-entry queue between front and back
// Lets the front classify the next quad while the back emits vertices.
// ============================================================================
`default_nettype none
module sqve_queue
  import sqve_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  quad_t      push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output quad_t      head
);

  quad_t       ent [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = ent[rptr];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/sqve_back.sv
// ============================================================================
// sqve_back: rotation and vertex emission
// Iterative CORDIC (one step a cycle), then per corner one product pair a
// cycle through a shared multiplier pair, rounding, saturation and output.
// ============================================================================
`default_nettype none
module sqve_back
  import sqve_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_empty,
  input  quad_t             q_head,
  output logic              q_pop,
  output logic              m_valid,
  input  wire logic         m_ready,
  output logic [31:0]       vert_x,
  output logic [31:0]       vert_y,
  output logic [31:0]       vert_z,
  output logic              tex_u,
  output logic              tex_v,
  output logic [31:0]       vert_colour,
  output logic [4:0]        tex_slot,
  output logic              slot_new,
  output logic [15:0]       vert_tiling,
  output logic [14:0]       vertex_addr,
  output logic [1:0]        status,
  output logic              last
);

  typedef enum logic [2:0] {B_IDLE, B_CORDIC, B_ROUND, B_MUL_A, B_MUL_B, B_SUM, B_OUT}
    state_t;

  state_t              state;
  quad_t               q;
  logic signed [33:0]  cx, cy, cz;
  logic [3:0]          step;
  logic signed [17:0]  c, s;
  logic [1:0]          corner;
  logic signed [65:0]  p0, p1;
  logic signed [66:0]  accx, accy;

  // CORDIC step, shift truncates toward zero
  logic signed [33:0]  dx, dy;
  assign dx = (cx < 0) ? -((-cx) >>> step) : (cx >>> step);
  assign dy = (cy < 0) ? -((-cy) >>> step) : (cy >>> step);

  // rounding of CORDIC result to Q1.15, clamped
  logic signed [33:0]  rx, ry;
  logic signed [17:0]  cr, sr;
  assign rx = (cx + 34'sd16384) >>> 15;
  assign ry = (cy + 34'sd16384) >>> 15;
  always_comb begin
    cr = (rx < 0) ? 18'sd0 : (rx > 34'sd32768) ? 18'sd32768 : 18'(rx);
    sr = (ry < 0) ? 18'sd0 : (ry > 34'sd32768) ? 18'sd32768 : 18'(ry);
  end

  // corner operands
  logic                u, v;
  logic signed [32:0]  lx, ly;
  assign u  = (corner == 2'd1) || (corner == 2'd2);
  assign v  = corner[1];
  assign lx = u ? 33'(q.size_x) : -33'(q.size_x);
  assign ly = v ? 33'(q.size_y) : -33'(q.size_y);

  // round to Q16.16 and saturate
  logic signed [50:0]  fx, fy;
  logic signed [51:0]  sx, sy;
  assign fx = 51'((accx + 67'sd32768) >>> 16);
  assign fy = 51'((accy + 67'sd32768) >>> 16);
  assign sx = 52'(q.pos_x) + 52'(fx);
  assign sy = 52'(q.pos_y) + 52'(fy);

  function automatic logic [31:0] sat(input logic signed [51:0] a);
    if (a > 52'sd2147483647)       sat = 32'h7FFF_FFFF;
    else if (a < -52'sd2147483648) sat = 32'h8000_0000;
    else                           sat = a[31:0];
  endfunction

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      m_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            q      <= q_head;
            corner <= '0;
            step   <= '0;
            cx     <= CORDIC_X0;
            cy     <= '0;
            cz     <= 34'({q_head.angle[13:0], 16'h0});
            if (q_head.status != ST_OK) begin
              vert_x      <= '0;
              vert_y      <= '0;
              vert_z      <= '0;
              tex_u       <= 1'b0;
              tex_v       <= 1'b0;
              vert_colour <= '0;
              tex_slot    <= '0;
              slot_new    <= 1'b0;
              vert_tiling <= '0;
              vertex_addr <= '0;
              status      <= q_head.status;
              last        <= 1'b1;
              m_valid     <= 1'b1;
              state       <= B_OUT;
            end else if (q_head.angle[13:0] == 14'd0) begin
              state <= B_ROUND;
            end else begin
              state <= B_CORDIC;
            end
          end
        end
        B_CORDIC: begin
          if (cz >= 0) begin
            cx <= cx - dy;
            cy <= cy + dx;
            cz <= cz - atan_turn(step);
          end else begin
            cx <= cx + dy;
            cy <= cy - dx;
            cz <= cz + atan_turn(step);
          end
          step <= step + 4'd1;
          if (step == 4'(CordicSteps - 1)) state <= B_ROUND;
        end
        B_ROUND: begin
          // exact on quarter turns, then fold quadrant
          logic signed [17:0] c0, s0;
          c0 = (q.angle[13:0] == 14'd0) ? 18'sd32768 : cr;
          s0 = (q.angle[13:0] == 14'd0) ? 18'sd0 : sr;
          case (q.angle[15:14])
            2'd0: begin c <= c0;  s <= s0;  end
            2'd1: begin c <= -s0; s <= c0;  end
            2'd2: begin c <= -c0; s <= -s0; end
            default: begin c <= s0; s <= -c0; end
          endcase
          state <= B_MUL_A;
        end
        B_MUL_A: begin
          p0    <= 66'(lx * c);
          p1    <= 66'(ly * s);
          state <= B_MUL_B;
        end
        B_MUL_B: begin
          accx  <= 67'(p0) - 67'(p1);
          p0    <= 66'(lx * s);
          p1    <= 66'(ly * c);
          state <= B_SUM;
        end
        B_SUM: begin
          accy  <= 67'(p0) + 67'(p1);
          state <= B_OUT;
          m_valid <= 1'b0;
        end
        B_OUT: begin
          if (!m_valid) begin
            vert_x      <= sat(sx);
            vert_y      <= sat(sy);
            vert_z      <= q.pos_z;
            tex_u       <= u;
            tex_v       <= v;
            vert_colour <= q.colour;
            tex_slot    <= q.slot;
            slot_new    <= q.fresh;
            vert_tiling <= q.tiling;
            vertex_addr <= q.base_addr + 15'(corner);
            status      <= ST_OK;
            last        <= (corner == 2'd3);
            m_valid     <= 1'b1;
          end else if (m_ready) begin
            m_valid <= 1'b0;
            if (last) begin
              state <= B_IDLE;
            end else begin
              corner <= corner + 2'd1;
              state  <= B_MUL_A;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/sprite_quad_vertex_expander.sv
// ============================================================================
// sprite_quad_vertex_expander: sprite quad to four vertices
// Top level joining intake/slot lookup, a two-entry queue and vertex back end.
// ============================================================================
// Each quad request gives four vertex beats (one beat with an error status
// when the slot table or quad buffer is full); begin-scene and code 3 give
// none. The back end takes a quad from the queue, runs 16 CORDIC steps,
// rounds and folds the quadrant, then handles each vertex through the
// shared multiplier pair (two product steps, a sum, the output load and the
// handshake). A quarter-turn angle skips the CORDIC steps, an error beat
// goes straight to the output, and every receiver stall adds to the vertex
// it holds. The front end accepts a request and then pushes an untextured
// quad; for a textured one each slot table entry compared takes a search
// state and a check state, and on a miss one more search state ends the
// search, one read port on the slot RAM; it overlaps with the back end
// through the two-entry queue.
`default_nettype none
module sprite_quad_vertex_expander
  import sqve_pkg::*;
#(
  parameter int MaxSlots = MaxSlotsDefault,
  parameter int MaxQuads = MaxQuadsDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // pos_x[31:0] pos_y[63:32] pos_z[95:64] angle[111:96]
  // size_x[143:112] size_y[175:144] texture_handle[207:176]
  // tiling[223:208] colour[255:224]
  input  wire logic [255:0]  s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // vert_x[31:0] vert_y[63:32] vert_z[95:64] tex_u[96] tex_v[97]
  // vert_colour[129:98] tex_slot[134:130] slot_new[135] vert_tiling[151:136]
  // vertex_addr[166:152], zero pad to 168
  output logic [167:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  logic   q_push, q_full, q_pop, q_empty;
  quad_t  q_in, q_head;

  logic [31:0] vx, vy, vz, vc;
  logic        tu, tv, sn;
  logic [4:0]  ts;
  logic [15:0] vt;
  logic [14:0] va;

  sqve_front #(.MaxSlots(MaxSlots), .MaxQuads(MaxQuads)) u_front (
    .clk            (clk),
    .rst            (rst),
    .s_valid        (s_axis_tvalid),
    .s_ready        (s_axis_tready),
    .req_type       (s_axis_tuser),
    .pos_x          (s_axis_tdata[31:0]),
    .pos_y          (s_axis_tdata[63:32]),
    .pos_z          (s_axis_tdata[95:64]),
    .angle          (s_axis_tdata[111:96]),
    .size_x         (s_axis_tdata[143:112]),
    .size_y         (s_axis_tdata[175:144]),
    .texture_handle (s_axis_tdata[207:176]),
    .tiling         (s_axis_tdata[223:208]),
    .colour         (s_axis_tdata[255:224]),
    .q_push         (q_push),
    .q_data         (q_in),
    .q_full         (q_full)
  );

  sqve_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sqve_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .vert_x      (vx),
    .vert_y      (vy),
    .vert_z      (vz),
    .tex_u       (tu),
    .tex_v       (tv),
    .vert_colour (vc),
    .tex_slot    (ts),
    .slot_new    (sn),
    .vert_tiling (vt),
    .vertex_addr (va),
    .status      (m_axis_tuser),
    .last        (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, va, vt, sn, ts, vc, tv, tu, vz, vy, vx};

endmodule
`default_nettype wire
